### hdl/ifa_pkg.sv
`timescale 1ns / 1ps

package ifa_pkg;

    // Fixed field widths of the stream payloads and the register.
    localparam int REF_W   = 10;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 10;
    localparam int LIMIT_W = 10;
    localparam int MARK_W  = 11;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = REF_W + STAT_W + CNT_W + CNT_W;

    // Operation carried in s_tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // List membership code kept per entry.
    localparam logic [1:0] LIST_NONE  = 2'd0;
    localparam logic [1:0] LIST_FREE  = 2'd1;
    localparam logic [1:0] LIST_ALLOC = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADFREE = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

    typedef struct packed {
        logic [CNT_W-1:0]  allocated_count;
        logic [CNT_W-1:0]  free_count;
        logic [STAT_W-1:0] status;
        logic [REF_W-1:0]  granted_ref;
    } result_t;

endpackage

### hdl/ifa_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ifa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/indexed_frame_allocator.sv
`timescale 1ns / 1ps

// Frame allocator over a table of FRAMES entries, entry 0 being the null entry.
// Each input beat carries the operation in s_tuser (0 allocate, 1 free) and the
// entry to free in s_tdata; each one yields exactly one result beat holding the
// granted entry, a status (0 ok, 1 no frame available, 2 bad free) and the
// lengths of the free and allocated lists after the operation. Freed entries are
// reused last-freed first; when none is free, never-used entries are handed out
// in ascending order up to frame_limit. The accept cycle launches one read of
// the link and owner memories, S_EXEC does the read-modify-write of the
// neighbor links, and S_DONE writes the freed entry's free-list link and,
// once the output is free, loads the output register. Only one operation is
// in flight at a time, and a result waiting in the output register does not
// block the next accept unless the following result is ready first.
// No clearing pass is needed after reset: ownership of an entry is trusted only
// below the high-water mark of entries ever handed out. Write frame_limit only
// while the block is idle.
module indexed_frame_allocator
    import ifa_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,    // frame_limit

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,        // [9:0] entry to free, [15:10] zero
    input  logic                 s_tuser,        // [0] func

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata         // [9:0] granted_ref, [11:10] status,
                                                 // [21:12] free_count,
                                                 // [31:22] allocated_count
);

    localparam int AW = $clog2(FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control and list registers.
    logic [1:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] frame_limit_reg;
    logic [AW-1:0]      free_head_reg, free_head_next;
    logic [AW-1:0]      alloc_tail_reg, alloc_tail_next;
    logic [CNT_W-1:0]   free_len_reg, free_len_next;
    logic [CNT_W-1:0]   alloc_len_reg, alloc_len_next;
    logic [MARK_W-1:0]  used_mark_reg, used_mark_next;
    logic               m_valid_reg, m_valid_next;

    // Item and result payload registers.
    logic               func_reg;
    logic [REF_W-1:0]   ref_reg;
    logic [REF_W-1:0]   granted_reg, granted_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_data_reg, pend_data_next;
    result_t            m_data_reg;

    // Memory ports.
    logic          next_we, prev_we, own_we, rd_en;
    logic [AW-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
    logic [AW-1:0] prev_waddr, prev_wdata, prev_rdata;
    logic [AW-1:0] own_waddr;
    logic [1:0]    own_wdata, own_rdata;

    logic          s_accept, out_free;
    logic [AW-1:0] s_ref_idx, ref_idx;
    logic [31:0]   s_ref_wide, ref_wide, cand_wide;
    logic [MARK_W-1:0] cand;
    logic          pop, fresh_ok, grant_ok, free_ok;
    logic [AW-1:0] h_idx, p_idx, n_idx;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign s_ref_wide = 32'(s_tdata[REF_W-1:0]);
    assign s_ref_idx  = s_ref_wide[AW-1:0];
    assign ref_wide   = 32'(ref_reg);
    assign ref_idx    = ref_wide[AW-1:0];

    // The read is launched on the accept edge; data is valid in S_EXEC.
    assign rd_en      = s_accept;
    assign next_raddr = (s_tuser == FUNC_ALLOC) ? free_head_reg : s_ref_idx;

    ifa_ram #(.WIDTH(AW), .DEPTH(FRAMES)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (rd_en),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    ifa_ram #(.WIDTH(AW), .DEPTH(FRAMES)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (rd_en),
        .raddr (s_ref_idx),
        .rdata (prev_rdata)
    );

    ifa_ram #(.WIDTH(2), .DEPTH(FRAMES)) u_owner_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .re    (rd_en),
        .raddr (s_ref_idx),
        .rdata (own_rdata)
    );

    // Allocation source: head of the free list, else the next never-used entry.
    assign pop       = (free_head_reg != '0);
    assign cand      = (used_mark_reg == '0) ? MARK_W'(1) : used_mark_reg;
    assign cand_wide = 32'(cand);
    assign fresh_ok  = (cand <= MARK_W'(frame_limit_reg)) && (cand_wide < 32'(FRAMES));
    assign grant_ok  = pop || fresh_ok;
    assign h_idx     = pop ? free_head_reg : cand_wide[AW-1:0];

    // Free checks. Owner codes are only meaningful below the high-water mark,
    // since entries above it were never written.
    assign free_ok = (ref_reg != '0) && (ref_wide < 32'(FRAMES))
                     && (ref_wide < 32'(used_mark_reg)) && (own_rdata == LIST_ALLOC);

    // The tail's forward link is never cleared in memory, so the tail is
    // recognized by compare instead.
    assign p_idx = prev_rdata;
    assign n_idx = (ref_idx == alloc_tail_reg) ? '0 : next_rdata;

    always_comb begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        alloc_tail_next = alloc_tail_reg;
        free_len_next   = free_len_reg;
        alloc_len_next  = alloc_len_reg;
        used_mark_next  = used_mark_reg;
        m_valid_next    = m_valid_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        pend_next       = pend_reg;
        pend_data_next  = pend_data_reg;

        next_we    = 1'b0;
        next_waddr = pend_data_reg;
        next_wdata = pend_data_reg;
        prev_we    = 1'b0;
        prev_waddr = h_idx;
        prev_wdata = alloc_tail_reg;
        own_we     = 1'b0;
        own_waddr  = h_idx;
        own_wdata  = LIST_ALLOC;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next   = S_DONE;
                granted_next = '0;
                status_next  = STAT_OK;
                pend_next    = 1'b0;
                if (func_reg == FUNC_ALLOC) begin
                    if (grant_ok) begin
                        // Append h behind the allocated tail.
                        next_we    = (alloc_tail_reg != '0);
                        next_waddr = alloc_tail_reg;
                        next_wdata = h_idx;
                        prev_we    = 1'b1;
                        prev_waddr = h_idx;
                        prev_wdata = alloc_tail_reg;
                        own_we     = 1'b1;
                        own_waddr  = h_idx;
                        own_wdata  = LIST_ALLOC;
                        alloc_tail_next = h_idx;
                        alloc_len_next  = alloc_len_reg + CNT_W'(1);
                        if (pop) begin
                            free_head_next = next_rdata;
                            free_len_next  = free_len_reg - CNT_W'(1);
                        end else begin
                            used_mark_next = cand + MARK_W'(1);
                        end
                        granted_next = REF_W'(32'(h_idx));
                    end else begin
                        status_next = STAT_EMPTY;
                    end
                end else if (ref_reg != '0) begin
                    if (free_ok) begin
                        // Unlink from the allocated list.
                        next_we    = (p_idx != '0);
                        next_waddr = p_idx;
                        next_wdata = n_idx;
                        prev_we    = (n_idx != '0);
                        prev_waddr = n_idx;
                        prev_wdata = p_idx;
                        if (n_idx == '0) begin
                            alloc_tail_next = p_idx;
                        end
                        own_we     = 1'b1;
                        own_waddr  = ref_idx;
                        own_wdata  = LIST_FREE;
                        // Push on the free-list head; its link is written next cycle.
                        pend_next      = 1'b1;
                        pend_data_next = free_head_reg;
                        free_head_next = ref_idx;
                        free_len_next  = free_len_reg + CNT_W'(1);
                        alloc_len_next = alloc_len_reg - CNT_W'(1);
                    end else begin
                        status_next = STAT_BADFREE;
                    end
                end
            end

            S_DONE: begin
                // Idempotent, so repeating it while the output is held is harmless.
                next_we    = pend_reg;
                next_waddr = ref_idx;
                next_wdata = pend_data_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            frame_limit_reg <= LIMIT_RESET;
            free_head_reg   <= '0;
            alloc_tail_reg  <= '0;
            free_len_reg    <= '0;
            alloc_len_reg   <= '0;
            used_mark_reg   <= '0;
            m_valid_reg     <= 1'b0;
            pend_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            alloc_tail_reg <= alloc_tail_next;
            free_len_reg   <= free_len_next;
            alloc_len_reg  <= alloc_len_next;
            used_mark_reg  <= used_mark_next;
            m_valid_reg    <= m_valid_next;
            pend_reg       <= pend_next;
            if (cfg_wr_en) begin
                frame_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tuser;
            ref_reg  <= s_tdata[REF_W-1:0];
        end
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        pend_data_reg <= pend_data_next;
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.granted_ref     <= granted_reg;
            m_data_reg.status          <= status_reg;
            m_data_reg.free_count      <= free_len_reg;
            m_data_reg.allocated_count <= alloc_len_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the frame allocator. Operations go in on the slave
// stream, one beat per operation, and every accepted beat is run through a
// behavioral copy of the free and allocated lists kept here. The copy yields
// the result beat the block must return. The result stream is compared
// field by field against those expectations, in order.
module tb;
    import ifa_pkg::*;

    localparam int NUM_FRAMES  = 1024;
    localparam int CYCLE_LIMIT = 600000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    indexed_frame_allocator #(
        .FRAMES(NUM_FRAMES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ------------------------------------------------------------------
    // Behavioral copy of the allocator state. Links are indexed by entry
    // number, entry 0 is the null entry and terminates both lists.
    // ------------------------------------------------------------------
    logic [REF_W-1:0]   link_next [NUM_FRAMES];
    logic [REF_W-1:0]   link_prev [NUM_FRAMES];
    logic [1:0]         owner     [NUM_FRAMES];
    logic [REF_W-1:0]   fl_head, fl_tail, al_head, al_tail;
    logic [CNT_W-1:0]   fl_len, al_len;
    logic [MARK_W-1:0]  high_water;
    logic [LIMIT_W-1:0] limit_reg;

    // Entries currently on the allocated list, used to build legal frees.
    int held_frames[$];

    // Expected result beats, oldest first.
    result_t pending_results[$];

    int errors;
    int ops_sent;
    int beats_checked;
    int n_grants;
    int n_exhausted;
    int n_bad_frees;
    int n_null_frees;
    int cycle_count;
    logic [STAT_W-1:0] last_status;

    // Idle profile, changed per test. A percentage of zero turns that
    // side's idling off for a stretch of traffic.
    int tx_gap_pct;
    int rx_stall_pct;
    int stall_left;

    // ------------------------------------------------------------------
    // Clock and cycle watchdog.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Picks an idle length: mostly short, now and then a long one.
    function automatic int pick_idle(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Result side back-pressure. m_tready changes only at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (aresetn) begin
            stall_left = pick_idle(rx_stall_pct);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // List model. Resets the copy to an empty table.
    // ------------------------------------------------------------------
    task automatic reset_frame_model();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            link_next[i] = '0;
            link_prev[i] = '0;
            owner[i]     = LIST_NONE;
        end
        fl_head    = '0;
        fl_tail    = '0;
        al_head    = '0;
        al_tail    = '0;
        fl_len     = '0;
        al_len     = '0;
        high_water = '0;
        limit_reg  = LIMIT_RESET;
        held_frames.delete();
    endtask

    // Applies one operation to the list copy and returns the result beat
    // that the block must produce for it.
    function automatic result_t predict_frame_op(input logic op,
                                                 input logic [REF_W-1:0] fref);
        result_t          res;
        logic [REF_W-1:0] e;
        logic [REF_W-1:0] p;
        logic [REF_W-1:0] n;
        int               cand;

        res = '0;
        res.status = STAT_OK;
        if (op == FUNC_ALLOC) begin
            e = '0;
            if (fl_head != '0) begin
                // Reuse the most recently freed entry.
                e = fl_head;
                n = link_next[e];
                if (n != '0)
                    link_prev[n] = '0;
                else
                    fl_tail = '0;
                fl_head = n;
                fl_len--;
                owner[e] = LIST_NONE;
            end else begin
                // No free entry: hand out the next never-used one if the
                // limit and the table size allow it.
                cand = (high_water == '0) ? 1 : int'(high_water);
                if (cand <= int'(limit_reg) && cand < NUM_FRAMES) begin
                    high_water = MARK_W'(cand + 1);
                    e = REF_W'(cand);
                end
            end
            if (e != '0) begin
                link_next[e] = '0;
                link_prev[e] = al_tail;
                if (al_tail != '0)
                    link_next[al_tail] = e;
                else
                    al_head = e;
                al_tail = e;
                owner[e] = LIST_ALLOC;
                al_len++;
                res.granted_ref = e;
                held_frames.insert(held_frames.size(), int'(e));
                n_grants++;
            end else begin
                res.status = STAT_EMPTY;
                n_exhausted++;
            end
        end else if (fref == '0) begin
            n_null_frees++;
        end else if (owner[fref] != LIST_ALLOC) begin
            res.status = STAT_BADFREE;
            n_bad_frees++;
        end else begin
            // Unlink from the allocated list...
            p = link_prev[fref];
            n = link_next[fref];
            if (p != '0)
                link_next[p] = n;
            else
                al_head = n;
            if (n != '0)
                link_prev[n] = p;
            else
                al_tail = p;
            al_len--;
            // ...then push onto the head of the free list.
            link_prev[fref] = '0;
            link_next[fref] = fl_head;
            if (fl_head != '0)
                link_prev[fl_head] = fref;
            else
                fl_tail = fref;
            fl_head = fref;
            owner[fref] = LIST_FREE;
            fl_len++;
            foreach (held_frames[i]) begin
                if (held_frames[i] == int'(fref)) begin
                    held_frames.delete(i);
                    break;
                end
            end
        end
        res.free_count      = fl_len;
        res.allocated_count = al_len;
        last_status = res.status;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers. Each call starts and ends just after a falling edge.
    // ------------------------------------------------------------------
    task automatic send_frame_op(input logic op, input logic [REF_W-1:0] fref);
        int      gap;
        result_t exp_res;
        gap = pick_idle(tx_gap_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(S_TDATA_W - REF_W){1'b0}}, fref};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The beat was taken at this edge; predict its result now.
        exp_res = predict_frame_op(op, fref);
        pending_results.insert(pending_results.size(), exp_res);
        ops_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Waits for every expected result, which leaves the block idle since
    // each operation yields exactly one result beat.
    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_frame_limit(input logic [LIMIT_W-1:0] value);
        wait_results_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        limit_reg = value;
    endtask

    // Free target: mostly an entry that is really held, sometimes the null
    // entry, sometimes any entry number at all.
    function automatic logic [REF_W-1:0] pick_free_ref();
        int r;
        r = $urandom_range(0, 99);
        if (held_frames.size() != 0 && r < 75)
            return REF_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
        if (r < 85)
            return '0;
        return REF_W'($urandom_range(0, NUM_FRAMES - 1));
    endfunction

    task automatic send_random_op(input int alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct)
            send_frame_op(FUNC_ALLOC, REF_W'($urandom_range(0, NUM_FRAMES - 1)));
        else
            send_frame_op(FUNC_FREE, pick_free_ref());
    endtask

    // ------------------------------------------------------------------
    // Result checker. Every beat taken on the master side is matched with
    // the oldest expectation.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        $display("Mismatch at result %0d: %s is %0d, expected %0d",
                 beats_checked, field, got, want);
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, granted_ref", int'(got.granted_ref), 0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.granted_ref != want.granted_ref)
                    report_mismatch("granted_ref", int'(got.granted_ref),
                                    int'(want.granted_ref));
                if (got.status != want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.free_count != want.free_count)
                    report_mismatch("free_count", int'(got.free_count),
                                    int'(want.free_count));
                if (got.allocated_count != want.allocated_count)
                    report_mismatch("allocated_count", int'(got.allocated_count),
                                    int'(want.allocated_count));
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Limit extremes right after reset: a limit of zero allows no fresh entry,
    // a limit of one allows exactly entry 1, while freed entries stay usable.
    task automatic test_limit_extremes();
        set_frame_limit('0);
        send_frame_op(FUNC_ALLOC, '0);
        set_frame_limit(LIMIT_W'(1));
        send_frame_op(FUNC_ALLOC, '1);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_FREE, REF_W'(1));
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_FREE, REF_W'(1));
    endtask

    // List surgery: frees of the null entry, of never-used entries and of
    // already freed ones, and unlinking at the middle, head and tail of the
    // allocated list, followed by last-freed-first reuse.
    task automatic test_list_edges();
        set_frame_limit(LIMIT_RESET);
        send_frame_op(FUNC_FREE, '0);
        send_frame_op(FUNC_FREE, '1);
        send_frame_op(FUNC_FREE, REF_W'(512));
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_FREE, REF_W'(2));
        send_frame_op(FUNC_FREE, REF_W'(2));
        send_frame_op(FUNC_FREE, REF_W'(1));
        send_frame_op(FUNC_FREE, REF_W'(4));
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_ALLOC, '0);
        send_frame_op(FUNC_FREE, '0);
    endtask

    // Mixed allocate and free traffic under one limit and one idle profile.
    task automatic test_random_traffic(input int n_ops, input int alloc_pct,
                                       input logic [LIMIT_W-1:0] limit_val,
                                       input int gap_pct, input int stall_pct);
        set_frame_limit(limit_val);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        repeat (n_ops) send_random_op(alloc_pct);
    endtask

    // Allocation-heavy traffic under a limit a little above the entries
    // handed out so far, until both the free list and the fresh entries are
    // used up and an allocate is refused.
    task automatic test_table_exhaustion();
        int guard;
        int lim;
        guard = 0;
        lim = int'(high_water) + 24;
        if (lim > NUM_FRAMES - 1)
            lim = NUM_FRAMES - 1;
        set_frame_limit(LIMIT_W'(lim));
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        last_status  = STAT_OK;
        while (!(fl_len == '0 && last_status == STAT_EMPTY) && guard < 400) begin
            send_random_op(85);
            guard++;
        end
        // A few frees and reallocations on the exhausted table.
        repeat (20) send_random_op(50);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_ALLOC;
        m_tready    = 1'b0;
        stall_left  = 0;
        tx_gap_pct  = 30;
        rx_stall_pct = 30;
        errors      = 0;
        ops_sent    = 0;
        beats_checked = 0;
        n_grants    = 0;
        n_exhausted = 0;
        n_bad_frees = 0;
        n_null_frees = 0;
        cycle_count = 0;
        last_status = STAT_OK;
        reset_frame_model();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_limit_extremes();
        test_list_edges();
        test_random_traffic(180, 60, LIMIT_RESET, 30, 30);
        test_random_traffic(130, 55, LIMIT_W'($urandom_range(20, 60)), 40, 10);
        test_random_traffic(100, 55, LIMIT_W'(1), 10, 40);
        test_random_traffic(180, 65, LIMIT_RESET, 0, 0);
        test_random_traffic(160, 60, LIMIT_W'($urandom_range(2, 1022)), 50, 50);
        test_table_exhaustion();

        wait_results_drained();
        repeat (8) @(posedge aclk);

        $display("Ran %0d operations: %0d grants, %0d refused allocates,",
                 ops_sent, n_grants, n_exhausted);
        $display("%0d bad frees, %0d null frees; checked %0d result beats, fresh entries up to %0d.",
                 n_bad_frees, n_null_frees, beats_checked, int'(high_water) - 1);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
